FILE: rtl/core/gmcsd_pkg.sv
// ----------------------------------------------------------------------------
// gmcsd_pkg
// Types and constants shared by the cycle-slip detector modules.
// ----------------------------------------------------------------------------
package gmcsd_pkg;

  // serial divider sizes
  localparam int unsigned DivW  = 50;
  localparam int unsigned DsrW  = 17;
  localparam int unsigned GsatW = 28;

  // detection constants
  localparam int unsigned MwJumpLimit  = 8192;
  localparam int unsigned GapMinSec    = 90;
  localparam int unsigned GfCapRaw     = 22937;
  localparam int unsigned GfElevKnee   = 3840;
  localparam int unsigned MwElevKnee   = 5120;
  localparam int unsigned ElevFull     = 7680;
  localparam int unsigned MwKneeFactor = 2560;
  localparam int unsigned CountMax     = 65535;

  typedef enum logic [2:0] {
    REASON_NONE = 3'd0,
    REASON_ARC  = 3'd1,
    REASON_GAP  = 3'd2,
    REASON_GF   = 3'd3,
    REASON_MW   = 3'd4,
    REASON_BOTH = 3'd5
  } reason_e;

  typedef enum logic [2:0] {
    CFG_MIN_ELEV  = 3'd0,
    CFG_MW_LIMIT  = 3'd1,
    CFG_GF_LIMIT  = 3'd2,
    CFG_MW_ON     = 3'd3,
    CFG_GF_ON     = 3'd4,
    CFG_GAP_ON    = 3'd5,
    CFG_GAP_LIMIT = 3'd6,
    CFG_INTERVAL  = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_GDIV,
    ST_CALC,
    ST_MSTART,
    ST_MDIV,
    ST_DONE
  } state_e;

  // per-channel history word
  typedef struct packed {
    logic        [15:0] count;
    logic        [31:0] secs;
    logic signed [47:0] gf;
    logic signed [31:0] raw_mw;
    logic signed [31:0] mean;
  } entry_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DsrW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
    logic [DsrW-1:0] rem;
  } div_rsp_t;

endpackage

FILE: rtl/core/gmcsd_div.sv
// ----------------------------------------------------------------------------
// gmcsd_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gmcsd_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gmcsd_pkg::div_req_t req_i,
  output gmcsd_pkg::div_rsp_t rsp_o
);
  import gmcsd_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] quo_q, quo_d;
  logic [DsrW-1:0] rem_q, rem_d, dsr_q, dsr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DsrW+1:0] trial;

  // one shift-subtract step
  always_comb begin
    trial  = {1'b0, rem_q, quo_q[DivW-1]} - {2'b00, dsr_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      cnt_d  = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DsrW+1]) begin
        rem_d = trial[DsrW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DsrW-2:0], quo_q[DivW-1]};
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: rtl/core/gmcsd_store.sv
// ----------------------------------------------------------------------------
// gmcsd_store
// Channel history memory and valid-bit memory with clearing pass after reset.
// ----------------------------------------------------------------------------
module gmcsd_store #(
  parameter int unsigned CHANNELS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_idx_i,
  input  logic              wr_en_i,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_idx_i,
  input  gmcsd_pkg::entry_t wr_entry_i,
  output logic              rd_valid_o,
  output gmcsd_pkg::entry_t rd_entry_o,
  output logic              clearing_o
);
  import gmcsd_pkg::*;

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  entry_t        mem [CHANNELS];
  logic          vmem [CHANNELS];
  logic [AW-1:0] clr_idx_q;
  logic          clr_busy_q;

  // clearing sweep over the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == AW'(CHANNELS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // valid memory
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      vmem[clr_idx_q] <= 1'b0;
    end else if (wr_en_i) begin
      vmem[wr_idx_i] <= 1'b1;
    end
    if (rd_en_i) begin
      rd_valid_o <= vmem[rd_idx_i];
    end
  end

  // history memory
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_entry_o <= mem[rd_idx_i];
    end
  end

  assign clearing_o = clr_busy_q;

endmodule

FILE: rtl/core/gnss_mw_gf_cycle_slip_detector.sv
// ----------------------------------------------------------------------------
// gnss_mw_gf_cycle_slip_detector
// Per-channel MW/GF cycle-slip detection over a channel history memory.
// ----------------------------------------------------------------------------
// Sequence: an accepted beat is evaluated; arc starts and ignored channels go
// straight to the result, others run the gap division, the slip tests and, with
// MW mean update, the mean division. Flow: one item at a time; the input is ready
// again in the cycle the result beat is first offered. The 50-step serial
// divider, used once for the gap count and once for the MW mean, is the longest step.
// Reset: config registers take their defaults, then a clearing pass over all
// CHANNELS entries zeroes the valid memory before the first beat is taken.
// ----------------------------------------------------------------------------
module gnss_mw_gf_cycle_slip_detector #(
  parameter int unsigned CHANNELS = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // fields from bit 0: channel, epoch_seconds, mw_value, gf_value, elevation
  input  logic [135:0] s_axis_tdata,
  // fields from bit 0: elevation_valid, lost_lock_first, lost_lock_second,
  // range_outlier
  input  logic [3:0]   s_axis_tuser,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // fields from bit 0: reason, mw_mean_out, epoch_count_out
  output logic [55:0]  m_axis_tdata,
  // fields from bit 0: slip
  output logic [0:0]   m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [19:0]  cfg_data_i
);
  import gmcsd_pkg::*;

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // config registers
  logic [14:0] min_elev_q;
  logic [15:0] mw_limit_q;
  logic [19:0] gf_limit_q;
  logic        mw_on_q, gf_on_q, gap_on_q;
  logic [15:0] gap_limit_q;
  logic [11:0] interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_elev_q  <= 15'd1792;
      mw_limit_q  <= 16'd4096;
      gf_limit_q  <= 20'd3277;
      mw_on_q     <= 1'b1;
      gf_on_q     <= 1'b1;
      gap_on_q    <= 1'b1;
      gap_limit_q <= 16'd20;
      interval_q  <= 12'd30;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_ELEV:  min_elev_q  <= cfg_data_i[14:0];
        CFG_MW_LIMIT:  mw_limit_q  <= cfg_data_i[15:0];
        CFG_GF_LIMIT:  gf_limit_q  <= cfg_data_i;
        CFG_MW_ON:     mw_on_q     <= cfg_data_i[0];
        CFG_GF_ON:     gf_on_q     <= cfg_data_i[0];
        CFG_GAP_ON:    gap_on_q    <= cfg_data_i[0];
        CFG_GAP_LIMIT: gap_limit_q <= cfg_data_i[15:0];
        CFG_INTERVAL:  interval_q  <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  logic [11:0] iv;
  logic [27:0] gap_prod;
  assign iv       = (interval_q == '0) ? 12'd1 : interval_q;
  assign gap_prod = 28'(gap_limit_q) * 28'(iv);

  // handshake and state
  state_e   state_q, state_d;
  logic     in_fire, out_free, clearing;
  logic     rd_valid;
  entry_t   old_e, new_e;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     eval_stop, mw_upd;
  logic     wr_en, out_load;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // captured beat
  logic [7:0]         chan_q;
  logic [31:0]        now_q;
  logic signed [31:0] mw_q;
  logic signed [47:0] gf_q;
  logic [14:0]        e_q;
  logic               lli_q, bad_q, oor_q;
  logic [14:0]        e_in;
  logic [AW+7:0]      rd_ext, wr_ext;

  always_comb begin
    if (!s_axis_tuser[0]) begin
      e_in = '0;
    end else if (s_axis_tdata[134:120] < min_elev_q) begin
      e_in = min_elev_q;
    end else begin
      e_in = s_axis_tdata[134:120];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      chan_q <= s_axis_tdata[7:0];
      now_q  <= s_axis_tdata[39:8];
      mw_q   <= $signed(s_axis_tdata[71:40]);
      gf_q   <= $signed(s_axis_tdata[119:72]);
      e_q    <= e_in;
      lli_q  <= s_axis_tuser[1] | s_axis_tuser[2];
      bad_q  <= s_axis_tuser[3];
      oor_q  <= (32'(s_axis_tdata[7:0]) >= CHANNELS);
    end
  end

  assign rd_ext = (AW + 8)'(s_axis_tdata[7:0]);
  assign wr_ext = (AW + 8)'(chan_q);

  gmcsd_store #(
    .CHANNELS(CHANNELS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_fire),
    .rd_idx_i   (rd_ext[AW-1:0]),
    .wr_en_i    (wr_en),
    .wr_idx_i   (wr_ext[AW-1:0]),
    .wr_entry_i (new_e),
    .rd_valid_o (rd_valid),
    .rd_entry_o (old_e),
    .clearing_o (clearing)
  );

  gmcsd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // first look at the history: restarts, gap measures and elevation factors
  logic signed [33:0] dt, gx;
  logic signed [32:0] jdiff;
  logic [32:0]        jump;
  logic               restart1, restart2;
  logic [12:0]        f_gf, g_mw;

  always_comb begin
    dt       = $signed({2'b00, now_q}) - $signed({2'b00, old_e.secs});
    gx       = dt - $signed({22'd0, iv});
    jdiff    = $signed({mw_q[31], mw_q}) - $signed({old_e.raw_mw[31], old_e.raw_mw});
    jump     = jdiff[32] ? 33'(-jdiff) : 33'(jdiff);
    restart1 = !rd_valid || lli_q;
    restart2 = (dt > $signed({22'd0, iv}) && jump > 33'(MwJumpLimit) && !bad_q) ||
               (gap_on_q && dt > $signed({6'd0, gap_prod}));
    f_gf     = (e_q < 15'(GfElevKnee)) ? 13'(ElevFull - 32'(e_q)) : 13'(GfElevKnee);
    g_mw     = (e_q < 15'(MwElevKnee)) ? 13'(ElevFull - 32'(e_q)) : 13'(MwKneeFactor);
  end

  assign eval_stop = oor_q || restart1 || restart2;
  assign mw_upd    = mw_on_q && !bad_q;

  logic [32:0]  p_q;
  logic [28:0]  mwb_q;
  logic         restart_q, gap90_q;
  reason_e      reason_q;
  logic [GsatW-1:0] gsat_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EVAL) begin
      p_q       <= 33'(gf_limit_q) * 33'(f_gf);
      mwb_q     <= 29'(mw_limit_q) * 29'(g_mw);
      gap90_q   <= (dt >= 34'sd90);
      restart_q <= restart1 || restart2;
      reason_q  <= restart1 ? REASON_ARC : REASON_GAP;
    end
    if (state_q == ST_GDIV && div_rsp.done) begin
      gsat_q <= (div_rsp.quot >= DivW'(1 << (GsatW - 1))) ?
                GsatW'(1 << (GsatW - 1)) : div_rsp.quot[GsatW-1:0];
    end
  end

  // slip tests and mean product
  logic [48:0]        dgf;
  logic signed [48:0] gdiff;
  logic [60:0]        lhs_full;
  logic [26:0]        lhs_cap;
  logic [GsatW-1:0]   pc;
  logic [2*GsatW-1:0] gprod;
  logic               gslip_c, mslip_c;
  logic signed [32:0] mdiff;
  logic [32:0]        dmw;
  logic [45:0]        mlhs;
  logic [31:0]        mrhs;
  logic [15:0]        nnew;

  always_comb begin
    gdiff    = $signed({gf_q[47], gf_q}) - $signed({old_e.gf[47], old_e.gf});
    dgf      = gdiff[48] ? 49'(-gdiff) : 49'(gdiff);
    lhs_full = {dgf, 12'd0} - {4'd0, dgf, 8'd0};
    lhs_cap  = {dgf[14:0], 12'd0} - {4'd0, dgf[14:0], 8'd0};
    pc       = (p_q >= 33'(1 << (GsatW - 1))) ? GsatW'(1 << (GsatW - 1)) : p_q[GsatW-1:0];
    gprod    = (2 * GsatW)'(pc) * (2 * GsatW)'(gsat_q);
    if (!gf_on_q) begin
      gslip_c = 1'b0;
    end else if (gap90_q && gsat_q >= GsatW'(3)) begin
      gslip_c = (dgf > 49'(GfCapRaw)) || ((2 * GsatW)'(lhs_cap) > gprod);
    end else begin
      gslip_c = lhs_full > 61'(p_q);
    end
    mdiff = $signed({mw_q[31], mw_q}) - $signed({old_e.mean[31], old_e.mean});
    dmw   = mdiff[32] ? 33'(-mdiff) : 33'(mdiff);
    mlhs  = {dmw, 13'd0} + {2'd0, dmw, 11'd0};
    if (gsat_q <= GsatW'(2)) begin
      mrhs = {1'b0, mwb_q, 2'd0};
    end else if (gsat_q <= GsatW'(4)) begin
      mrhs = {1'b0, mwb_q, 2'd0} + 32'(mwb_q);
    end else if (gsat_q <= GsatW'(8)) begin
      mrhs = {1'b0, mwb_q, 2'd0} + {2'd0, mwb_q, 1'b0};
    end else begin
      mrhs = {mwb_q, 3'd0};
    end
    mslip_c = mw_upd && (mw_limit_q != '0) && (mlhs > 46'(mrhs));
    nnew    = (old_e.count < 16'(CountMax)) ? old_e.count + 1'b1 : old_e.count;
  end

  logic               gslip_q, mslip_q;
  logic [15:0]        nnew_q;
  logic signed [48:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EVAL) begin
      gslip_q <= 1'b0;
      mslip_q <= 1'b0;
    end else if (state_q == ST_CALC) begin
      gslip_q <= gslip_c;
      mslip_q <= mslip_c;
      nnew_q  <= nnew;
      prod_q  <= 49'(old_e.mean) * 49'($signed({1'b0, nnew - 1'b1}));
    end
  end

  // mean numerator and rounding
  logic signed [49:0] sum50;
  logic signed [50:0] num51;
  logic [49:0]        num_mag;
  logic               neg_q;
  logic [49:0]        qfix;
  logic signed [31:0] mean_q;

  always_comb begin
    sum50   = 50'(prod_q) + 50'(mw_q);
    num51   = {sum50, 1'b0} + $signed({35'd0, nnew_q});
    num_mag = num51[50] ? 50'(-num51) : num51[49:0];
    qfix    = neg_q ? 50'(-(div_rsp.quot + 50'(div_rsp.rem != '0))) : div_rsp.quot;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MSTART) begin
      neg_q <= num51[50];
    end
    if (state_q == ST_MDIV && div_rsp.done) begin
      mean_q <= $signed(qfix[31:0]);
    end
  end

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    if (state_q == ST_EVAL) begin
      div_req.start    = !eval_stop;
      div_req.dividend = gx[33] ? '0 : 50'(gx[32:0]);
      div_req.divisor  = 17'(iv);
    end else if (state_q == ST_MSTART) begin
      div_req.start    = 1'b1;
      div_req.dividend = num_mag;
      div_req.divisor  = {nnew_q, 1'b0};
    end
  end

  // write-back word and result
  logic    restart_f;
  reason_e reason_f;

  always_comb begin
    restart_f = restart_q || gslip_q || mslip_q;
    if (restart_q) begin
      reason_f = reason_q;
    end else if (gslip_q && mslip_q) begin
      reason_f = REASON_BOTH;
    end else if (gslip_q) begin
      reason_f = REASON_GF;
    end else if (mslip_q) begin
      reason_f = REASON_MW;
    end else begin
      reason_f = REASON_NONE;
    end
    if (restart_f) begin
      new_e.count  = 16'd1;
      new_e.secs   = now_q;
      new_e.gf     = gf_q;
      new_e.raw_mw = mw_q;
      new_e.mean   = mw_q;
    end else begin
      new_e.count  = mw_upd ? nnew_q : old_e.count;
      new_e.secs   = mw_upd ? now_q : old_e.secs;
      new_e.gf     = gf_on_q ? gf_q : old_e.gf;
      new_e.raw_mw = mw_upd ? mw_q : old_e.raw_mw;
      new_e.mean   = mw_upd ? mean_q : old_e.mean;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_EVAL;
      ST_EVAL:   state_d = eval_stop ? ST_DONE : ST_GDIV;
      ST_GDIV:   if (div_rsp.done) state_d = ST_CALC;
      ST_CALC:   state_d = mw_upd ? ST_MSTART : ST_DONE;
      ST_MSTART: state_d = ST_MDIV;
      ST_MDIV:   if (div_rsp.done) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    wr_en         = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = !clearing;
      ST_DONE: begin
        out_load = out_free;
        wr_en    = out_free && !oor_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output stage
  logic        out_valid_q;
  logic [55:0] out_data_q;
  logic        out_slip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (oor_q) begin
        out_data_q <= '0;
        out_slip_q <= 1'b0;
      end else begin
        out_data_q <= {5'd0, new_e.count, new_e.mean, reason_f};
        out_slip_q <= (reason_f != REASON_NONE);
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_slip_q;

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MW/GF cycle-slip detector. A directed table
// covers arc starts, lost lock, gaps, MW jumps, GF, MW and double slips and
// the field extremes. Random per-channel arcs follow, under several register
// settings and idling patterns. Results of typed table rows are checked against
// the row's values, all others against an in-bench predictor of the per-channel history.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gmcsd_pkg::*;

  localparam int unsigned NCH       = 256;
  localparam int unsigned MaxCycles = 1000000;
  localparam int unsigned DrainWait = 150;

  typedef struct packed {
    logic [7:0]         chan;
    logic [31:0]        secs;
    logic signed [31:0] mw;
    logic signed [47:0] gf;
    logic [14:0]        elev;
    logic               ev;
    logic               llf;
    logic               lls;
    logic               outl;
  } obs_t;

  typedef struct packed {
    logic               slip;
    reason_e            reason;
    logic signed [31:0] mean;
    logic [15:0]        count;
  } slip_res_t;

  typedef struct {
    obs_t      o;
    bit        typed;
    slip_res_t r;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [135:0] s_axis_tdata = '0;
  logic [3:0]   s_axis_tuser = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [55:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [19:0]  cfg_data_i = '0;

  gnss_mw_gf_cycle_slip_detector u_top (.*);

  always #2 clk_i = ~clk_i;

  // register copies
  logic [14:0] min_elev_q;
  logic [15:0] mw_limit_q;
  logic [19:0] gf_limit_q;
  logic        mw_on_q, gf_on_q, gap_on_q;
  logic [15:0] gap_limit_q;
  logic [11:0] interval_q;

  // per-channel history copy
  bit                 hist_valid [NCH];
  logic [15:0]        hist_count [NCH];
  logic [31:0]        hist_secs  [NCH];
  logic signed [47:0] hist_gf    [NCH];
  logic signed [31:0] hist_raw   [NCH];
  logic signed [31:0] hist_mean  [NCH];

  // stimulus-side arc trackers
  logic [31:0]        trk_secs [16];
  logic signed [31:0] trk_mw   [16];
  logic signed [47:0] trk_gf   [16];

  slip_res_t   expected_q[$];
  int unsigned errors, n_sent, n_checked, n_slips, cycles;
  int unsigned send_idle_pct, recv_stall_pct;
  row_t        rows[$];

  function automatic longint unsigned mag(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function automatic longint floor_div(longint num, longint den);
    longint q;
    q = num / den;
    if (num % den != 0 && num < 0) q--;
    return q;
  endfunction

  function automatic void start_arc(int c, obs_t o);
    hist_valid[c] = 1'b1;
    hist_count[c] = 16'd1;
    hist_secs[c]  = o.secs;
    hist_gf[c]    = o.gf;
    hist_raw[c]   = o.mw;
    hist_mean[c]  = o.mw;
  endfunction

  // predicted detector decision, updates the history copy
  function automatic slip_res_t predict_slip(obs_t o);
    slip_res_t r;
    int c;
    longint e, iv, dt, g, n, sum;
    longint unsigned jump, d, f, p, lhs, ug, gm, s;
    logic signed [31:0] old;
    bit gslip, mslip;
    c = o.chan;
    r.reason = REASON_NONE;
    gslip = 0;
    mslip = 0;
    if (o.ev) e = (o.elev < min_elev_q) ? longint'(min_elev_q) : longint'(o.elev);
    else e = 0;
    if (!hist_valid[c] || o.llf || o.lls) begin
      start_arc(c, o);
      r.reason = REASON_ARC;
    end else begin
      iv   = interval_q == 0 ? 1 : longint'(interval_q);
      dt   = longint'(o.secs) - longint'(hist_secs[c]);
      jump = mag(longint'(o.mw) - longint'(hist_raw[c]));
      if ((dt > iv && jump > MwJumpLimit && !o.outl) ||
          (gap_on_q && dt > longint'(gap_limit_q) * iv)) begin
        start_arc(c, o);
        r.reason = REASON_GAP;
      end else begin
        g = (dt - iv) / iv;
        if (gf_on_q) begin
          d   = mag(longint'(o.gf) - longint'(hist_gf[c]));
          f   = e < GfElevKnee ? longint'(ElevFull) - e : longint'(GfElevKnee);
          p   = longint'(gf_limit_q) * f;
          lhs = d * GfElevKnee;
          hist_gf[c] = o.gf;
          if (dt >= longint'(GapMinSec) && g >= 3) begin
            ug = g;
            gslip = ((p == 0 || ug <= 64'hFFFF_FFFF_FFFF_FFFF / p) && lhs > p * ug) ||
                    d > GfCapRaw;
          end else begin
            gslip = lhs > p;
          end
        end
        if (mw_on_q && !o.outl) begin
          old = hist_mean[c];
          if (hist_count[c] < CountMax) hist_count[c]++;
          hist_secs[c] = o.secs;
          hist_raw[c]  = o.mw;
          n   = hist_count[c];
          sum = longint'(old) * (n - 1) + longint'(o.mw);
          hist_mean[c] = 32'(floor_div(2 * sum + n, 2 * n));
          gm = e < MwElevKnee ? longint'(ElevFull) - e : longint'(MwKneeFactor);
          s  = g <= 2 ? 4 : g <= 4 ? 5 : g <= 8 ? 6 : 8;
          d  = mag(longint'(o.mw) - longint'(old));
          mslip = mw_limit_q != 0 && d * 10240 > longint'(mw_limit_q) * gm * s;
        end
        if (gslip || mslip) begin
          start_arc(c, o);
          r.reason = (gslip && mslip) ? REASON_BOTH : gslip ? REASON_GF : REASON_MW;
        end
      end
    end
    r.slip  = r.reason != REASON_NONE;
    r.mean  = hist_mean[c];
    r.count = hist_count[c];
    return r;
  endfunction

  function automatic void add_row(logic [7:0] ch, logic [31:0] t, int mw, longint gf,
                                  int el, bit ev, bit llf, bit lls, bit outl,
                                  bit typed = 0, reason_e rs = REASON_NONE,
                                  int mean = 0, int cnt = 0);
    row_t w;
    w.o = '{ch, t, mw, gf[47:0], el[14:0], ev, llf, lls, outl};
    w.typed = typed;
    w.r = '{rs != REASON_NONE, rs, mean, cnt[15:0]};
    rows.insert(rows.size(), w);
  endfunction

  // random item: mostly continuing arcs on a few channels, some noise
  function automatic obs_t gen_obs();
    obs_t o;
    int k, step;
    longint iv;
    iv = interval_q == 0 ? 1 : interval_q;
    if ($urandom_range(99) < 15) begin
      o = '{8'($urandom_range(255)), $urandom, $urandom, 48'({$urandom, $urandom}),
            15'($urandom_range(23040)), 1'($urandom), 1'($urandom), 1'($urandom),
            1'($urandom)};
      return o;
    end
    k = $urandom_range(15);
    step = $urandom_range(99);
    if (step < 70)      trk_secs[k] = trk_secs[k] + 32'(iv);
    else if (step < 85) trk_secs[k] = trk_secs[k] + 32'(iv * $urandom_range(2, 12));
    else if (step < 92)
      trk_secs[k] = trk_secs[k] + 32'(iv * (longint'(gap_limit_q) + $urandom_range(1, 3)));
    else if (step < 96) trk_secs[k] -= $urandom_range(1, 100);
    trk_mw[k] += $urandom_range(99) < 90 ? int'($urandom_range(1000)) - 500
                                          : int'($urandom_range(40000)) - 20000;
    trk_gf[k] = trk_gf[k] + 48'($urandom_range(99) < 85 ?
                                longint'($urandom_range(6000)) - 3000 :
                                longint'($urandom_range(200000)) - 100000);
    o.chan = 8'(k * 16 + 3);
    o.secs = trk_secs[k];
    o.mw   = trk_mw[k];
    o.gf   = trk_gf[k];
    o.elev = 15'($urandom_range(23040));
    o.ev   = $urandom_range(9) != 0;
    o.llf  = $urandom_range(99) < 3;
    o.lls  = $urandom_range(99) < 3;
    o.outl = $urandom_range(99) < 6;
    return o;
  endfunction

  task automatic send_obs(obs_t o, bit typed, slip_res_t typed_r);
    slip_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = {1'b0, o.elev, o.gf, o.mw, o.secs, o.chan};
    s_axis_tuser  = {o.outl, o.lls, o.llf, o.ev};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_slip(o);
    expected_q.insert(expected_q.size(), typed ? typed_r : r);
    n_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [19:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    case (idx)
      CFG_MIN_ELEV:  min_elev_q  = val[14:0];
      CFG_MW_LIMIT:  mw_limit_q  = val[15:0];
      CFG_GF_LIMIT:  gf_limit_q  = val[19:0];
      CFG_MW_ON:     mw_on_q     = val[0];
      CFG_GF_ON:     gf_on_q     = val[0];
      CFG_GAP_ON:    gap_on_q    = val[0];
      CFG_GAP_LIMIT: gap_limit_q = val[15:0];
      CFG_INTERVAL:  interval_q  = val[11:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch in %s at result %0d: got %0h, want %0h", field, n_checked,
             got, want);
    errors++;
  endtask

  // receiver stalls
  always @(negedge clk_i) m_axis_tready <= $urandom_range(99) >= recv_stall_pct;

  // result check
  always @(posedge clk_i) begin
    slip_res_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        w = expected_q.pop_front();
        if (m_axis_tuser[0] !== w.slip) report_mismatch("slip", m_axis_tuser[0], w.slip);
        if (m_axis_tdata[2:0] !== w.reason) report_mismatch("reason", m_axis_tdata[2:0], w.reason);
        if (m_axis_tdata[34:3] !== w.mean) report_mismatch("mw_mean", m_axis_tdata[34:3], w.mean);
        if (m_axis_tdata[50:35] !== w.count)
          report_mismatch("epoch_count", m_axis_tdata[50:35], w.count);
        if (w.slip) n_slips++;
      end
      n_checked++;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("timeout waiting for results");
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int ph, i;
    min_elev_q = 1792; mw_limit_q = 4096; gf_limit_q = 3277;
    mw_on_q = 1; gf_on_q = 1; gap_on_q = 1; gap_limit_q = 20; interval_q = 30;
    for (i = 0; i < 16; i++) begin
      trk_secs[i] = $urandom;
      trk_mw[i]   = $urandom;
      trk_gf[i]   = 48'({$urandom, $urandom});
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table, default registers
    add_row(0, 1000, 0, 0, 23040, 1, 0, 0, 0, 1, REASON_ARC, 0, 1);
    add_row(0, 1030, 100, 100, 23040, 1, 0, 0, 0);
    add_row(1, 0, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 0, 0, 0, 0, 0,
            1, REASON_ARC, 32'h7FFF_FFFF, 1);
    add_row(2, 32'hFFFF_FFFF, 32'h8000_0000, -64'sh8000_0000_0000, 23040, 1, 0, 0, 0,
            1, REASON_ARC, 32'h8000_0000, 1);
    add_row(0, 1060, 200, 0, 23040, 1, 1, 0, 0, 1, REASON_ARC, 200, 1);
    add_row(0, 1090, 200, 0, 23040, 1, 0, 1, 0, 1, REASON_ARC, 200, 1);
    add_row(0, 1720, 300, 0, 23040, 1, 0, 0, 0, 1, REASON_GAP, 300, 1);
    add_row(0, 1780, 10300, 0, 23040, 1, 0, 0, 0, 1, REASON_GAP, 10300, 1);
    add_row(0, 1810, 10300, 1000000, 23040, 1, 0, 0, 0, 1, REASON_GF, 10300, 1);
    add_row(0, 1840, 15300, 1000000, 23040, 1, 0, 0, 0, 1, REASON_MW, 15300, 1);
    add_row(0, 1870, 10300, 0, 23040, 1, 0, 0, 0, 1, REASON_BOTH, 10300, 1);
    add_row(0, 1900, 10300, 0, 23040, 1, 0, 0, 1);
    add_row(0, 1800, 10350, 50, 23040, 1, 0, 0, 0);
    add_row(0, 1930, 10400, 80, 23040, 0, 0, 0, 0);
    add_row(3, 5000, -5000, -100, 0, 1, 0, 0, 0, 1, REASON_ARC, -5000, 1);
    add_row(3, 5030, -5003, -100, 0, 1, 0, 0, 0);
    add_row(3, 5180, -5003, 3900, 23040, 1, 0, 0, 0);
    add_row(3, 5780, -5001, 3950, 1000, 1, 0, 0, 0);
    add_row(255, 77, 1, 1, 22000, 1, 0, 0, 0, 1, REASON_ARC, 1, 1);
    add_row(255, 108, 2, 2, 22000, 1, 0, 0, 0);
    foreach (rows[k]) send_obs(rows[k].o, rows[k].typed, rows[k].r);
    drain();

    // random phases under changing registers and idling
    for (ph = 0; ph < 5; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      case (ph)
        1: begin
          write_reg(CFG_MIN_ELEV, 0);      write_reg(CFG_MW_LIMIT, 16'hFFFF);
          write_reg(CFG_GF_LIMIT, 20'hFFFFF); write_reg(CFG_INTERVAL, 1);
          write_reg(CFG_GAP_LIMIT, 1);
        end
        2: begin
          write_reg(CFG_MIN_ELEV, 23040);  write_reg(CFG_MW_LIMIT, 0);
          write_reg(CFG_GF_LIMIT, 0);      write_reg(CFG_MW_ON, 0);
          write_reg(CFG_GF_ON, 0);         write_reg(CFG_GAP_ON, 0);
          write_reg(CFG_GAP_LIMIT, 16'hFFFF); write_reg(CFG_INTERVAL, 3600);
        end
        3: begin
          write_reg(CFG_MW_ON, 1);         write_reg(CFG_GF_LIMIT, 2000);
          write_reg(CFG_MW_LIMIT, 2048);   write_reg(CFG_INTERVAL, 15);
          write_reg(CFG_GAP_LIMIT, 8);
        end
        4: begin
          write_reg(CFG_GF_ON, 1);         write_reg(CFG_GAP_ON, 1);
          write_reg(CFG_MIN_ELEV, 1792);   write_reg(CFG_MW_LIMIT, 4096);
          write_reg(CFG_GF_LIMIT, 3277);   write_reg(CFG_INTERVAL, 30);
          write_reg(CFG_GAP_LIMIT, 20);
        end
        default: ;
      endcase
      for (i = 0; i < 80; i++) begin
        send_obs(gen_obs(), 0, '0);
        // hold off once until everything in flight has come back
        if (ph == 0 && i == 40)
          while (expected_q.size() != 0) @(negedge clk_i);
      end
      drain();
    end

    $display("sent %0d observations, checked %0d results, %0d of them slips",
             n_sent, n_checked, n_slips);
    $display("five register settings, extremes included, under four idling patterns");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/gmcsd_pkg.sv
rtl/core/gmcsd_div.sv
rtl/core/gmcsd_store.sv
rtl/core/gnss_mw_gf_cycle_slip_detector.sv
verif/tb.sv
